// ===== rtl/positional_list_insert_delete_macros.svh =====
// assertion macros for the positional list block
// used by the top level only; needs nothing else
`ifndef POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH
`define POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH

// same-cycle implication, checked out of reset
`define PLD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PLD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pld_pkg.sv =====
// shared types and codes for the positional list block
// no dependencies
`default_nettype none

package pld_pkg;

  localparam int POS_W  = 7;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } pld_op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } pld_status_t;

  // shift command broadcast to every cell
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] value;
  } pld_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/positional_list_insert_delete.sv =====
// Positional list of signed 32-bit entries held in a row of CAPACITY cells.
// Every request gives one response, registered: the response for a request
// accepted at one edge is offered from the next cycle. A new request is taken
// in every cycle in which the response register is empty or its response is
// being taken, so the block sustains one request per cycle; an insert or
// delete shifts all cells at or above the position at the edge that accepts it.
// Depends on pld_pkg, pld_cell and positional_list_insert_delete_macros.svh.
`default_nettype none
`include "positional_list_insert_delete_macros.svh"

module positional_list_insert_delete
  import pld_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     req_valid,
  output logic                          req_stall,
  input  wire logic [1:0]               operation,
  input  wire logic [POS_W-1:0]         position,
  input  wire logic signed [DATA_W-1:0] value,
  output logic                          rsp_valid,
  input  wire logic                     rsp_stall,
  output logic [1:0]                    status,
  output logic [POS_W-1:0]              list_length,
  output logic signed [DATA_W-1:0]      read_value
);

  localparam int LW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (LW > POS_W) ? LW : POS_W;

  logic [LW-1:0]     length;
  logic [LW-1:0]     length_next;
  logic              req_fire;
  logic [CMPW-1:0]   pos_c;
  logic [CMPW-1:0]   len_c;
  logic              full;
  logic [1:0]        status_next;
  logic              ins_ok;
  logic              del_ok;
  logic              rd_ok;
  pld_cmd_t          cmd;
  logic [DATA_W-1:0] cell_q  [CAPACITY];
  logic [DATA_W-1:0] rd_term [CAPACITY];
  logic [DATA_W-1:0] rd_any;

  assign req_stall = rsp_valid && rsp_stall;
  assign req_fire  = req_valid && !req_stall;

  assign pos_c = CMPW'(position);
  assign len_c = CMPW'(length);
  assign full  = length == LW'(CAPACITY);

  always_comb begin
    ins_ok      = 1'b0;
    del_ok      = 1'b0;
    rd_ok       = 1'b0;
    status_next = ST_RANGE;
    unique case (operation)
      OP_INSERT: begin
        if (pos_c > len_c) begin
          status_next = ST_RANGE;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          ins_ok      = 1'b1;
          status_next = ST_DONE;
        end
      end
      OP_DELETE: begin
        if (pos_c < len_c) begin
          del_ok      = 1'b1;
          status_next = ST_DONE;
        end
      end
      OP_READ: begin
        if (pos_c < len_c) begin
          rd_ok       = 1'b1;
          status_next = ST_DONE;
        end
      end
      default: status_next = ST_RANGE;
    endcase
  end

  always_comb begin
    length_next = length;
    if (ins_ok) begin
      length_next = length + LW'(1);
    end else if (del_ok) begin
      length_next = length - LW'(1);
    end
  end

  assign cmd.ins      = req_fire && ins_ok;
  assign cmd.del      = req_fire && del_ok;
  assign cmd.position = position;
  assign cmd.value    = value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end
    pld_cell #(
      .INDEX(i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .left_data (left_d),
      .right_data(right_d),
      .data      (cell_q[i]),
      .rd_term   (rd_term[i])
    );
  end

  // at most one cell matches the position
  always_comb begin
    rd_any = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_any = rd_any | rd_term[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_fire) begin
        length    <= length_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      status      <= status_next;
      list_length <= POS_W'(length_next);
      read_value  <= rd_ok ? rd_any : '0;
    end
  end

  `PLD_ASSERT_NOW(a_len_bound, clk, rst, 1'b1, length <= LW'(CAPACITY), "length above capacity")
  `PLD_ASSERT_NEXT(a_rsp_follows, clk, rst, req_fire, rsp_valid, "request without response")
  `PLD_ASSERT_NEXT(a_len_hold, clk, rst, !req_fire, $stable(length), "length moved with no request")
  `PLD_ASSERT_NOW(a_full_len, clk, rst, rsp_valid && status == ST_FULL, list_length == POS_W'(CAPACITY), "full status below capacity")

endmodule

`default_nettype wire

// ===== rtl/pld_cell.sv =====
// one list slot: holds an entry and takes a neighbor's entry on a shift
// depends on pld_pkg
`default_nettype none

module pld_cell
  import pld_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  wire logic              clk,
  input  wire pld_cmd_t          cmd,
  input  wire logic [DATA_W-1:0] left_data,
  input  wire logic [DATA_W-1:0] right_data,
  output logic      [DATA_W-1:0] data,
  output logic      [DATA_W-1:0] rd_term
);

  logic at_pos;
  logic above_pos;

  assign at_pos    = 32'(cmd.position) == 32'(INDEX);
  assign above_pos = 32'(INDEX) > 32'(cmd.position);

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (at_pos) begin
        data <= cmd.value;
      end else if (above_pos) begin
        data <= left_data;
      end
    end else if (cmd.del) begin
      if (at_pos || above_pos) begin
        data <= right_data;
      end
    end
  end

  // gated entry for the read or-tree
  assign rd_term = at_pos ? data : '0;

endmodule

`default_nettype wire

// ===== tb/positional_list_insert_delete_tb.sv =====
// self-checking testbench for positional_list_insert_delete: drives insert, delete
// and read requests with random idling and stalls, predicts every response in order
// depends on pld_pkg and the positional_list_insert_delete top level
`default_nettype none

module positional_list_insert_delete_tb;
  import pld_pkg::*;

  localparam int CAPACITY = 64;
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct {
    logic [1:0]               op;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
  } list_req_t;

  typedef struct {
    pld_status_t              status;
    logic [POS_W-1:0]         length;
    logic signed [DATA_W-1:0] rd;
  } list_rsp_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     req_valid = 1'b0;
  logic                     req_stall;
  logic [1:0]               operation = '0;
  logic [POS_W-1:0]         position = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     rsp_valid;
  logic                     rsp_stall = 1'b0;
  logic [1:0]               status;
  logic [POS_W-1:0]         list_length;
  logic signed [DATA_W-1:0] read_value;

  positional_list_insert_delete #(.CAPACITY(CAPACITY)) dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .operation(operation), .position(position), .value(value),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .status(status), .list_length(list_length), .read_value(read_value)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  list_req_t pending_reqs[$];
  list_rsp_t expected_rsps[$];

  // predicted list contents
  logic signed [DATA_W-1:0] list_store [CAPACITY];
  int list_len = 0;

  int  idle_pct = 0;
  int  stall_pct = 0;
  logic req_fire = 1'b0;
  int  err_count = 0;
  int  req_count = 0;
  int  rsp_count = 0;
  int  done_count = 0;
  int  range_count = 0;
  int  full_count = 0;
  int  peak_len = 0;
  int  empty_count = 0;

  // generator side view of the length, used to aim positions and to steer the operation mix
  int gen_len = 0;
  bit growing = 1'b1;
  int full_tries = 0;

  function automatic list_rsp_t apply_request(list_req_t r);
    list_rsp_t rsp;
    rsp.status = ST_RANGE;
    rsp.rd = '0;
    case (r.op)
      OP_INSERT: begin
        // range check wins over the full check
        if (r.pos > list_len) begin
          rsp.status = ST_RANGE;
        end else if (list_len >= CAPACITY) begin
          rsp.status = ST_FULL;
        end else begin
          for (int i = list_len; i > r.pos; i--) list_store[i] = list_store[i-1];
          list_store[r.pos] = r.val;
          list_len++;
          rsp.status = ST_DONE;
        end
      end
      OP_DELETE: begin
        if (r.pos < list_len) begin
          for (int i = r.pos; i + 1 < list_len; i++) list_store[i] = list_store[i+1];
          list_len--;
          rsp.status = ST_DONE;
        end
      end
      OP_READ: begin
        if (r.pos < list_len) begin
          rsp.rd = list_store[r.pos];
          rsp.status = ST_DONE;
        end
      end
      default: ;
    endcase
    rsp.length = list_len[POS_W-1:0];
    return rsp;
  endfunction

  // request side: new request only once the current one has been taken
  always @(negedge clk) begin : req_drive
    list_req_t req_item;
    if (rst) begin
      req_valid <= 1'b0;
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (!req_valid || req_fire) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
          req_item = pending_reqs.pop_front();
          operation <= req_item.op;
          position <= req_item.pos;
          value <= req_item.val;
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : rsp_check
    list_req_t seen;
    list_rsp_t want;
    if (rst) begin
      req_fire <= 1'b0;
    end else begin
      req_fire <= req_valid && !req_stall;
      // responses come from earlier requests, so check before predicting
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          err_count++;
          $display("%0t: response with nothing expected: status %0d length %0d value %0d",
                   $time, status, list_length, read_value);
        end else begin
          want = expected_rsps.pop_front();
          rsp_count++;
          if (status !== want.status) begin
            err_count++;
            $display("%0t: status mismatch, expected %0d got %0d", $time, want.status, status);
          end
          if (list_length !== want.length) begin
            err_count++;
            $display("%0t: list_length mismatch, expected %0d got %0d",
                     $time, want.length, list_length);
          end
          if (read_value !== want.rd) begin
            err_count++;
            $display("%0t: read_value mismatch, expected %0d got %0d",
                     $time, want.rd, read_value);
          end
        end
      end
      if (req_valid && !req_stall) begin
        seen.op = operation;
        seen.pos = position;
        seen.val = value;
        want = apply_request(seen);
        expected_rsps.push_back(want);
        req_count++;
        case (want.status)
          ST_DONE: done_count++;
          ST_FULL: full_count++;
          default: range_count++;
        endcase
        if (list_len > peak_len) peak_len = list_len;
        if (want.status == ST_DONE && seen.op == OP_DELETE && list_len == 0) empty_count++;
      end
    end
  end

  task automatic add_req(input logic [1:0] op, input int pos,
                         input logic signed [DATA_W-1:0] val);
    list_req_t r;
    r.op = op;
    r.pos = pos[POS_W-1:0];
    r.val = val;
    pending_reqs.push_back(r);
    if (op == OP_INSERT && pos <= gen_len && gen_len < CAPACITY) gen_len++;
    else if (op == OP_DELETE && pos < gen_len) gen_len--;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  // mostly in-range traffic that swings the list between empty and full
  task automatic add_random_req();
    logic [1:0] op;
    int pos;
    int roll;
    int limit;
    roll = $urandom_range(99);
    if (roll < 10) begin
      op = 2'($urandom_range(3));
      pos = $urandom_range(127);
    end else if (gen_len == CAPACITY && growing) begin
      op = OP_INSERT;
      pos = $urandom_range(CAPACITY);
      full_tries++;
      if (full_tries >= 3) growing = 1'b0;
    end else begin
      if (gen_len == 0) begin
        growing = 1'b1;
        full_tries = 0;
      end
      roll = $urandom_range(99);
      if (gen_len == 0 || roll < (growing ? 55 : 15)) op = OP_INSERT;
      else if (roll < 70) op = OP_DELETE;
      else op = OP_READ;
      limit = (op == OP_INSERT) ? gen_len : gen_len - 1;
      case ($urandom_range(4))
        0: pos = 0;
        1: pos = limit;
        default: pos = $urandom_range(limit);
      endcase
    end
    add_req(op, pos, pick_value());
  endtask

  task automatic run_phase(input int idle, input int stall, input int count);
    idle_pct = idle;
    stall_pct = stall;
    repeat (count) add_random_req();
    while (pending_reqs.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // empty list, bad positions and the spare opcode
    add_req(OP_READ, 0, $urandom());
    add_req(OP_DELETE, 0, $urandom());
    add_req(OP_INSERT, 1, 32'sd5);
    add_req(OP_SPARE, 0, $urandom());
    // build min, 0, max, -1 using front, end and middle inserts
    add_req(OP_INSERT, 0, 32'sh7FFFFFFF);
    add_req(OP_INSERT, 0, 32'sh80000000);
    add_req(OP_INSERT, 2, -32'sd1);
    add_req(OP_INSERT, 1, 32'sd0);
    add_req(OP_INSERT, 5, 32'sd9);
    for (int i = 0; i < 4; i++) add_req(OP_READ, i, $urandom());
    add_req(OP_READ, 4, $urandom());
    add_req(OP_READ, 127, $urandom());
    add_req(OP_DELETE, 4, $urandom());
    add_req(OP_DELETE, 1, $urandom());
    add_req(OP_DELETE, 2, $urandom());
    add_req(OP_DELETE, 0, $urandom());
    add_req(OP_READ, 0, $urandom());
    add_req(OP_INSERT, 127, -32'sd1);
    add_req(OP_SPARE, 127, -32'sd1);
    add_req(OP_DELETE, 0, $urandom());
    add_req(OP_READ, 0, $urandom());
    while (pending_reqs.size() != 0) @(posedge clk);

    run_phase(0, 0, 300);
    run_phase(55, 0, 300);
    run_phase(0, 55, 300);
    run_phase(28, 28, 300);
    run_phase(0, 0, 150);

    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    idle_pct = 0;

    $display("summary: %0d requests, %0d responses checked (%0d done, %0d out of range, %0d full)",
             req_count, rsp_count, done_count, range_count, full_count);
    $display("summary: list peaked at %0d of %0d entries and was emptied by delete %0d times",
             peak_len, CAPACITY, empty_count);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
